// File: sv/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the binary to decimal ASCII unit
// Field widths, BCD layout, handoff struct and the emitter state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

	localparam int VALUE_W        = 32;
	localparam int DIGIT_W        = 4;
	localparam int BCD_DIGITS     = 10;
	localparam int BCD_W          = BCD_DIGITS * DIGIT_W;
	localparam int ASCII_W        = 6;
	localparam int BIT_CNT_W      = $clog2(VALUE_W);
	localparam int REM_W          = $clog2(BCD_DIGITS + 1);
	localparam int MAX_DIGITS_DEF = 10;

	localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'h30;
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ = 4'd3;

	// Result of the binary to BCD conversion, handed to the emitter.
	typedef struct packed {
		logic             done;
		logic [BCD_W-1:0] bcd;
	} bda_conv_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SKIP,
		ST_EMIT
	} bda_state_t;

	// Add three to one BCD digit when it is five or more, ahead of a shift.
	function automatic logic [DIGIT_W-1:0] dabble_adj(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] r;
		r = d;
		if (d >= DIGIT_ADJ_MIN) begin
			r = d + DIGIT_ADJ;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/bda_convert.sv
// ----------------------------------------------------------------------------
// bda_convert: bit-serial binary to BCD converter
// Shifts the binary value into a BCD register one bit per cycle, with an
// add-three adjust on every digit lane before each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_convert (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [bda_pkg::VALUE_W-1:0]       value,
	output logic                                   busy,
	output bda_pkg::bda_conv_t                     conv
);

	logic [bda_pkg::VALUE_W-1:0]  bin_q;
	logic [bda_pkg::BCD_W-1:0]    bcd_q;
	logic [bda_pkg::BCD_W-1:0]    bcd_adj;
	logic [bda_pkg::BIT_CNT_W-1:0] cnt_q;
	logic                         run_q;
	logic                         done_q;

	// Adjust each digit lane independently.
	always_comb begin
		for (int i = 0; i < bda_pkg::BCD_DIGITS; i++) begin
			bcd_adj[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] =
				bda_pkg::dabble_adj(bcd_q[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bda_pkg::BIT_CNT_W'(bda_pkg::VALUE_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the next binary bit (MSB first) into the adjusted BCD word.
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (run_q) begin
			bin_q <= {bin_q[bda_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[bda_pkg::BCD_W-2:0], bin_q[bda_pkg::VALUE_W-1]};
		end
	end

	assign busy      = run_q | done_q;
	assign conv.done = done_q;
	assign conv.bcd  = bcd_q;

endmodule

`default_nettype wire

// File: sv/bda_emit.sv
// ----------------------------------------------------------------------------
// bda_emit: digit emitter
// Drops digits above the limit and leading zero digits one per cycle, then
// shifts out the rest as ASCII, most significant first, flagging the last.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_emit #(
	parameter int MAX_DIGITS = bda_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bda_pkg::bda_conv_t            conv,
	output logic                               busy,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [bda_pkg::ASCII_W-1:0]        ascii_digit,
	output logic                               last_digit
);

	localparam int LIMIT = (MAX_DIGITS < 1) ? 1 : MAX_DIGITS;
	localparam int CMP_W = $clog2(((LIMIT > bda_pkg::BCD_DIGITS) ? LIMIT
	                                : bda_pkg::BCD_DIGITS) + 1);
	localparam logic [CMP_W-1:0] LIMIT_V = CMP_W'(LIMIT);

	bda_pkg::bda_state_t            state_q;
	bda_pkg::bda_state_t            state_nxt;
	logic [bda_pkg::BCD_W-1:0]      digits_q;
	logic [bda_pkg::REM_W-1:0]      rem_q;
	logic                           seen_q;
	logic [bda_pkg::DIGIT_W-1:0]    top_digit;
	logic                           rem_one;
	logic                           skip_cond;
	logic                           take;
	logic                           advance;
	logic                           load;

	assign top_digit = digits_q[bda_pkg::BCD_W-1 -: bda_pkg::DIGIT_W];
	assign rem_one   = (rem_q == bda_pkg::REM_W'(1));
	// Drop digits above the limit, or a leading zero while more than one remains.
	// Once a nonzero digit has been dropped, the zeros below it are kept.
	assign skip_cond = (CMP_W'(rem_q) > LIMIT_V)
	                   || ((top_digit == '0) && !rem_one && !seen_q);
	assign take      = out_valid && !out_stall;
	assign advance   = ((state_q == bda_pkg::ST_SKIP) && skip_cond) || take;
	assign load      = conv.done && (state_q == bda_pkg::ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bda_pkg::ST_IDLE: begin
				if (conv.done) begin
					state_nxt = bda_pkg::ST_SKIP;
				end
			end
			bda_pkg::ST_SKIP: begin
				if (!skip_cond) begin
					state_nxt = bda_pkg::ST_EMIT;
				end
			end
			bda_pkg::ST_EMIT: begin
				if (take && rem_one) begin
					state_nxt = bda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bda_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = (state_q != bda_pkg::ST_IDLE);
		out_valid = (state_q == bda_pkg::ST_EMIT);
	end

	assign ascii_digit = bda_pkg::ASCII_W'(bda_pkg::ASCII_ZERO
	                     + {{(bda_pkg::ASCII_W-bda_pkg::DIGIT_W){1'b0}}, top_digit});
	assign last_digit  = rem_one;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bda_pkg::ST_IDLE;
			rem_q   <= '0;
			seen_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				rem_q  <= bda_pkg::REM_W'(bda_pkg::BCD_DIGITS);
				seen_q <= 1'b0;
			end else if (advance) begin
				rem_q <= rem_q - 1'b1;
				if ((state_q == bda_pkg::ST_SKIP) && (top_digit != '0)) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= conv.bcd;
		end else if (advance) begin
			digits_q <= {digits_q[bda_pkg::BCD_W-bda_pkg::DIGIT_W-1:0],
			             {bda_pkg::DIGIT_W{1'b0}}};
		end
	end

endmodule

`default_nettype wire

// File: sv/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit: 32-bit binary to decimal ASCII text
// Converts one unsigned value into its decimal digits, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / value): one item is one 32-bit
//   unsigned number. The unit holds in_stall high from the cycle after an
//   accept until the last digit of that number has been taken.
//   Output channel (out_valid / out_stall / ascii_digit / last_digit): one
//   item per decimal digit, '0'..'9' as ASCII, leading zeros dropped, zero
//   itself giving a single '0'. last_digit marks the final digit. With
//   MAX_DIGITS below the digit count only the low MAX_DIGITS digits appear.
//   Timing: bit-serial double dabble over the 32 input bits, a handoff to
//   the emitter, one dropped leading digit (0 to 9) per cycle, then entry
//   to emit before the first digit shows. Digits then follow one per cycle
//   while out_stall is low. Dropped plus emitted digits are always ten.
//   An item holds the unit until its last digit has been taken; one item
//   is in work at a time.
//   Stalling: while out_stall is high the current digit and last_digit hold.
//   Reset: arst_n clears the control state; the unit comes up idle.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_unit #(
	parameter int MAX_DIGITS = bda_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [bda_pkg::VALUE_W-1:0]   value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [bda_pkg::ASCII_W-1:0]        ascii_digit,
	output logic                               last_digit
);

	logic               conv_busy;
	logic               emit_busy;
	logic               start;
	bda_pkg::bda_conv_t conv;

	// Take a new number only when converter and emitter are both free.
	assign in_stall = conv_busy | emit_busy;
	assign start    = in_valid && !in_stall;

	bda_convert u_convert (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (value),
		.busy   (conv_busy),
		.conv   (conv)
	);

	bda_emit #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.conv        (conv),
		.busy        (emit_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ascii_digit (ascii_digit),
		.last_digit  (last_digit)
	);

endmodule

`default_nettype wire

// File: sv/bda_checker.sv
// ----------------------------------------------------------------------------
// bda_checker: port-level checks for binary_to_decimal_ascii_unit
// Watches the top-level channels over time; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [bda_pkg::ASCII_W-1:0]   ascii_digit,
	input wire logic                          last_digit
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(ascii_digit) && $stable(last_digit))
		else $error("output item changed while stalled");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ascii_digit >= bda_pkg::ASCII_ZERO)
		              && (ascii_digit <= bda_pkg::ASCII_ZERO + 6'd9))
		else $error("ascii_digit outside '0'..'9'");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("unit not busy after accepting an item");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_digit |=> !out_valid)
		else $error("output item after the last digit");

endmodule

bind binary_to_decimal_ascii_unit bda_checker u_bda_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.ascii_digit (ascii_digit),
	.last_digit  (last_digit)
);

`default_nettype wire
